/* design/pwmd_pkg.sv */
// ----------------------------------------------------------------------------
// pwmd_pkg
// Shared widths, register indexes, codes and types of the pulse-width decoder.
// ----------------------------------------------------------------------------
package pwmd_pkg;

    localparam int COUNT_W  = 24;
    localparam int TIME_W   = 48;
    localparam int MAX_BITS = 64;
    localparam int BITS_W   = 7;
    localparam int POS_W    = 6;
    localparam int ERR_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 24;
    localparam int IN_W     = 8;
    localparam int RES_W    = MAX_BITS + ERR_W + 2 * TIME_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_IS_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_IS_SHORT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_FRAME   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST    = 3'd7;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TIMEOUT   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_SHORT = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 2'd3;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_IDLE   = 2'd1;
    localparam logic [1:0] PH_ACTIVE = 2'd2;

    typedef struct packed {
        logic               idle_is_high;
        logic               one_is_short;
        logic [COUNT_W-1:0] min_pulse;
        logic [COUNT_W-1:0] threshold;
        logic [COUNT_W-1:0] max_pulse;
        logic [COUNT_W-1:0] max_gap;
        logic [BITS_W-1:0]  bits_per_frame;
        logic               msb_first;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]   end_sample;
        logic [TIME_W-1:0]   start_sample;
        logic [ERR_W-1:0]    error_code;
        logic [MAX_BITS-1:0] frame_data;
    } result_t;

endpackage

/* design/pwmd_core.sv */
// ----------------------------------------------------------------------------
// pwmd_core
// Decoder state and the per-sample update: pulse and gap measurement, bit
// packing and frame termination.
// ----------------------------------------------------------------------------
module pwmd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                level,
    input  pwmd_pkg::cfg_t      cfg,
    output logic                emit,
    output pwmd_pkg::result_t   result
);

    logic [pwmd_pkg::TIME_W-1:0]   sample_index_reg, sample_index_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [pwmd_pkg::COUNT_W-1:0]  pulse_length_reg, pulse_length_next;
    logic [pwmd_pkg::COUNT_W-1:0]  gap_length_reg, gap_length_next;
    logic [pwmd_pkg::BITS_W-1:0]   bit_count_reg, bit_count_next;
    logic [pwmd_pkg::MAX_BITS-1:0] shift_data_reg, shift_data_next;
    logic [pwmd_pkg::TIME_W-1:0]   frame_start_reg, frame_start_next;
    logic [pwmd_pkg::TIME_W-1:0]   last_end_reg, last_end_next;

    logic                          active;
    logic [pwmd_pkg::COUNT_W-1:0]  pulse_inc;
    logic [pwmd_pkg::COUNT_W-1:0]  gap_inc;
    logic [pwmd_pkg::BITS_W-1:0]   count_inc;
    logic [pwmd_pkg::BITS_W-1:0]   frame_len;
    logic [pwmd_pkg::BITS_W-1:0]   pos;
    logic                          bit_val;
    logic [pwmd_pkg::MAX_BITS-1:0] data_with_bit;
    logic [pwmd_pkg::ERR_W-1:0]    pulse_err;

    assign active    = level ^ cfg.idle_is_high;
    assign pulse_inc = (pulse_length_reg == '1) ? pulse_length_reg : pulse_length_reg + 1'b1;
    assign gap_inc   = (gap_length_reg == '1) ? gap_length_reg : gap_length_reg + 1'b1;
    assign count_inc = (bit_count_reg == '1) ? bit_count_reg : bit_count_reg + 1'b1;

    always_comb
    begin
        if (cfg.bits_per_frame == '0)
            frame_len = pwmd_pkg::BITS_W'(1);
        else if (cfg.bits_per_frame > pwmd_pkg::BITS_W'(pwmd_pkg::MAX_BITS))
            frame_len = pwmd_pkg::BITS_W'(pwmd_pkg::MAX_BITS);
        else
            frame_len = cfg.bits_per_frame;
    end

    // bit placement for the pulse that ends on this sample
    always_comb
    begin
        pos = cfg.msb_first ? (frame_len - pwmd_pkg::BITS_W'(1) - bit_count_reg)
                            : bit_count_reg;
        bit_val = (pulse_length_reg < cfg.threshold) ? cfg.one_is_short : ~cfg.one_is_short;
        data_with_bit = shift_data_reg;
        if (bit_count_reg < frame_len && bit_val)
            data_with_bit = shift_data_reg
                | (pwmd_pkg::MAX_BITS'(1) << pos[pwmd_pkg::POS_W-1:0]);
        if (pulse_length_reg < cfg.min_pulse)
            pulse_err = pwmd_pkg::ERR_TOO_SHORT;
        else if (pulse_length_reg > cfg.max_pulse)
            pulse_err = pwmd_pkg::ERR_TOO_LONG;
        else
            pulse_err = pwmd_pkg::ERR_NONE;
    end

    always_comb
    begin
        sample_index_next  = sample_index_reg + 1'b1;
        phase_next         = phase_reg;
        pulse_length_next  = pulse_length_reg;
        gap_length_next    = gap_length_reg;
        bit_count_next     = bit_count_reg;
        shift_data_next    = shift_data_reg;
        frame_start_next   = frame_start_reg;
        last_end_next      = last_end_reg;
        emit               = 1'b0;
        result.frame_data   = shift_data_reg;
        result.error_code   = pwmd_pkg::ERR_TIMEOUT;
        result.start_sample = frame_start_reg;
        result.end_sample   = last_end_reg;

        case (phase_reg)
            pwmd_pkg::PH_IDLE:
            begin
                if (active)
                begin
                    phase_next        = pwmd_pkg::PH_ACTIVE;
                    pulse_length_next = pwmd_pkg::COUNT_W'(1);
                    if (bit_count_reg == '0)
                        frame_start_next = sample_index_reg;
                end
                else if (bit_count_reg != '0)
                begin
                    gap_length_next = gap_inc;
                    if (gap_inc > cfg.max_gap)
                        emit = 1'b1;
                end
            end
            pwmd_pkg::PH_ACTIVE:
            begin
                if (active)
                    pulse_length_next = pulse_inc;
                else
                begin
                    phase_next         = pwmd_pkg::PH_IDLE;
                    gap_length_next    = pwmd_pkg::COUNT_W'(1);
                    last_end_next      = sample_index_reg;
                    bit_count_next     = count_inc;
                    shift_data_next    = data_with_bit;
                    result.frame_data  = data_with_bit;
                    result.end_sample  = sample_index_reg;
                    if (pulse_err != pwmd_pkg::ERR_NONE)
                    begin
                        emit              = 1'b1;
                        result.error_code = pulse_err;
                    end
                    else if (count_inc >= frame_len)
                    begin
                        emit              = 1'b1;
                        result.error_code = pwmd_pkg::ERR_NONE;
                    end
                    else if (cfg.max_gap == '0)
                        emit = 1'b1;
                end
            end
            default:
            begin
                if (!active)
                begin
                    phase_next      = pwmd_pkg::PH_IDLE;
                    gap_length_next = '0;
                end
                else
                    phase_next = pwmd_pkg::PH_WAIT;
            end
        endcase

        if (emit)
        begin
            bit_count_next  = '0;
            shift_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            phase_reg        <= pwmd_pkg::PH_WAIT;
            pulse_length_reg <= '0;
            gap_length_reg   <= '0;
            bit_count_reg    <= '0;
            shift_data_reg   <= '0;
            frame_start_reg  <= '0;
            last_end_reg     <= '0;
        end
        else if (advance)
        begin
            sample_index_reg <= sample_index_next;
            phase_reg        <= phase_next;
            pulse_length_reg <= pulse_length_next;
            gap_length_reg   <= gap_length_next;
            bit_count_reg    <= bit_count_next;
            shift_data_reg   <= shift_data_next;
            frame_start_reg  <= frame_start_next;
            last_end_reg     <= last_end_next;
        end
    end

endmodule

/* design/pwm_pulse_width_bit_decoder.sv */
// ----------------------------------------------------------------------------
// pwm_pulse_width_bit_decoder
// Decodes pulse-width-coded bits from one line sample per item into frames.
// ----------------------------------------------------------------------------
// path: a frame result reaches the output through the input register, then
//   decode into the result register
// throughput: one sample per clock; a frame-ending sample waits while a result is held
// reset: all control state cleared, configuration at its defaults, decoder
//   waits for an idle line; no clearing pass
module pwm_pulse_width_bit_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [pwmd_pkg::IN_W-1:0]       s_axis_tdata,   // line_level
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // frame_data, error_code, start_sample, end_sample
    output logic [pwmd_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [pwmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwmd_pkg::CFG_W-1:0]      cfg_data
);

    pwmd_pkg::cfg_t    cfg_reg;
    pwmd_pkg::result_t result;
    pwmd_pkg::result_t out_data_reg;
    logic              in_valid_reg;
    logic              in_level_reg;
    logic              out_valid_reg;
    logic              emit;
    logic              fire;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready || !emit);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pwmd_pkg::OUT_W'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_is_high   <= 1'b0;
            cfg_reg.one_is_short   <= 1'b0;
            cfg_reg.min_pulse      <= pwmd_pkg::COUNT_W'(2);
            cfg_reg.threshold      <= pwmd_pkg::COUNT_W'(40);
            cfg_reg.max_pulse      <= pwmd_pkg::COUNT_W'(100);
            cfg_reg.max_gap        <= pwmd_pkg::COUNT_W'(200);
            cfg_reg.bits_per_frame <= pwmd_pkg::BITS_W'(24);
            cfg_reg.msb_first      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwmd_pkg::REG_IDLE_IS_HIGH: cfg_reg.idle_is_high <= cfg_data[0];
                pwmd_pkg::REG_ONE_IS_SHORT: cfg_reg.one_is_short <= cfg_data[0];
                pwmd_pkg::REG_MIN_PULSE:    cfg_reg.min_pulse    <= cfg_data;
                pwmd_pkg::REG_THRESHOLD:    cfg_reg.threshold    <= cfg_data;
                pwmd_pkg::REG_MAX_PULSE:    cfg_reg.max_pulse    <= cfg_data;
                pwmd_pkg::REG_MAX_GAP:      cfg_reg.max_gap      <= cfg_data;
                pwmd_pkg::REG_BITS_FRAME:
                    cfg_reg.bits_per_frame <= cfg_data[pwmd_pkg::BITS_W-1:0];
                pwmd_pkg::REG_MSB_FIRST:    cfg_reg.msb_first    <= cfg_data[0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_level_reg <= s_axis_tdata[0];
    end

    pwmd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .level   (in_level_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_data_reg <= result;
    end

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> m_axis_tvalid)
        else $error("decoded frame not presented");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a blocked result");

    a_held_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_level_reg))
        else $error("pending sample lost");

endmodule

/* tb/pwmd_frame_checker.sv */
// ----------------------------------------------------------------------------
// pwmd_frame_checker
// Watches the sample, result and register-write ports of the pulse-width
// decoder, tracks line phase, pulse and gap counts and the frame being built,
// and compares each frame on the output with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwmd_frame_checker
    import pwmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // line_level
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // frame_data, error_code, start_sample, end_sample
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   frames_pending,
    output int                   frames_checked
);

    cfg_t                cfg_q;
    logic [TIME_W-1:0]   sample_now;
    logic [1:0]          line_phase;
    logic [COUNT_W-1:0]  pulse_run;
    logic [COUNT_W-1:0]  gap_run;
    logic [BITS_W-1:0]   bits_taken;
    logic [MAX_BITS-1:0] frame_bits;
    logic [TIME_W-1:0]   frame_start;
    logic [TIME_W-1:0]   pulse_end;
    result_t             frames_due[$];
    result_t             got_frame;
    result_t             want_frame;
    int                  n_bad;
    int                  n_seen;

    task automatic close_frame(input logic [ERR_W-1:0] err);
        result_t r;
        r.frame_data   = frame_bits;
        r.error_code   = err;
        r.start_sample = frame_start;
        r.end_sample   = pulse_end;
        frames_due.push_back(r);
        bits_taken = '0;
        frame_bits = '0;
    endtask

    task automatic decode_sample(input logic level);
        logic [TIME_W-1:0]  now;
        logic               active;
        logic [COUNT_W-1:0] width;
        logic [BITS_W-1:0]  span;
        logic [ERR_W-1:0]   err;
        logic               symbol;
        logic [POS_W-1:0]   pos;
        now        = sample_now;
        active     = level != cfg_q.idle_is_high;
        sample_now = now + 1'b1;
        case (line_phase)
            PH_IDLE:
            begin
                if (active)
                begin
                    line_phase = PH_ACTIVE;
                    pulse_run  = 1;
                    if (bits_taken == 0)
                        frame_start = now;
                end
                else if (bits_taken != 0)
                begin
                    if (gap_run != '1)
                        gap_run = gap_run + 1'b1;
                    if (gap_run > cfg_q.max_gap)
                        close_frame(ERR_TIMEOUT);
                end
            end
            PH_ACTIVE:
            begin
                if (active)
                begin
                    if (pulse_run != '1)
                        pulse_run = pulse_run + 1'b1;
                end
                else
                begin
                    width = pulse_run;
                    span  = cfg_q.bits_per_frame;
                    if (span == 0)
                        span = 1;
                    else if (span > MAX_BITS)
                        span = BITS_W'(MAX_BITS);
                    err = ERR_NONE;
                    if (width < cfg_q.min_pulse)
                        err = ERR_TOO_SHORT;
                    else if (width > cfg_q.max_pulse)
                        err = ERR_TOO_LONG;
                    symbol = (width < cfg_q.threshold) ? cfg_q.one_is_short
                                                       : ~cfg_q.one_is_short;
                    // bits beyond a shortened frame are dropped
                    if (bits_taken < span)
                    begin
                        pos = cfg_q.msb_first ? POS_W'(span - 1 - bits_taken)
                                              : POS_W'(bits_taken);
                        frame_bits[pos] = frame_bits[pos] | symbol;
                    end
                    if (bits_taken != '1)
                        bits_taken = bits_taken + 1'b1;
                    pulse_end  = now;
                    line_phase = PH_IDLE;
                    gap_run    = 1;
                    if (err != ERR_NONE)
                        close_frame(err);
                    else if (bits_taken >= span)
                        close_frame(ERR_NONE);
                    else if (gap_run > cfg_q.max_gap)
                        close_frame(ERR_TIMEOUT);
                end
            end
            default:
            begin
                // waiting for an idle line, the spare code included
                if (!active)
                begin
                    line_phase = PH_IDLE;
                    gap_run    = 0;
                end
                else
                    line_phase = PH_WAIT;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_q.idle_is_high   = 1'b0;
            cfg_q.one_is_short   = 1'b0;
            cfg_q.min_pulse      = 2;
            cfg_q.threshold      = 40;
            cfg_q.max_pulse      = 100;
            cfg_q.max_gap        = 200;
            cfg_q.bits_per_frame = 24;
            cfg_q.msb_first      = 1'b1;
            sample_now  = '0;
            line_phase  = PH_WAIT;
            pulse_run   = '0;
            gap_run     = '0;
            bits_taken  = '0;
            frame_bits  = '0;
            frame_start = '0;
            pulse_end   = '0;
            frames_due.delete();
            n_bad  = 0;
            n_seen = 0;
            fail_count     <= 0;
            frames_pending <= 0;
            frames_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IDLE_IS_HIGH: cfg_q.idle_is_high   = cfg_data[0];
                    REG_ONE_IS_SHORT: cfg_q.one_is_short   = cfg_data[0];
                    REG_MIN_PULSE:    cfg_q.min_pulse      = cfg_data[COUNT_W-1:0];
                    REG_THRESHOLD:    cfg_q.threshold      = cfg_data[COUNT_W-1:0];
                    REG_MAX_PULSE:    cfg_q.max_pulse      = cfg_data[COUNT_W-1:0];
                    REG_MAX_GAP:      cfg_q.max_gap        = cfg_data[COUNT_W-1:0];
                    REG_BITS_FRAME:   cfg_q.bits_per_frame = cfg_data[BITS_W-1:0];
                    REG_MSB_FIRST:    cfg_q.msb_first      = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_sample(s_axis_tdata[0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_frame = m_axis_tdata[RES_W-1:0];
                n_seen++;
                if (frames_due.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected frame: data %h err %0d start %0d end %0d",
                                 got_frame.frame_data, got_frame.error_code,
                                 got_frame.start_sample, got_frame.end_sample);
                end
                else
                begin
                    want_frame = frames_due.pop_front();
                    if (got_frame.frame_data !== want_frame.frame_data
                        || got_frame.error_code !== want_frame.error_code
                        || got_frame.start_sample !== want_frame.start_sample
                        || got_frame.end_sample !== want_frame.end_sample)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $display("frame mismatch, expected data %h err %0d start %0d end %0d",
                                     want_frame.frame_data, want_frame.error_code,
                                     want_frame.start_sample, want_frame.end_sample);
                            $display("                 actual data %h err %0d start %0d end %0d",
                                     got_frame.frame_data, got_frame.error_code,
                                     got_frame.start_sample, got_frame.end_sample);
                        end
                    end
                end
            end
            fail_count     <= n_bad;
            frames_pending <= frames_due.size();
            frames_checked <= n_seen;
        end
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives line samples into the pulse-width decoder under many register
// settings, with random idle on the sample and frame ports, and takes the
// verdict from the frame checker beside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pwmd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;   // line_level
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // frame_data, error_code, start_sample, end_sample
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;

    int          chk_fails;
    int          chk_pending;
    int          chk_frames;
    int          cycle_count = 0;
    int          items_sent  = 0;
    int          n_configs   = 0;
    int          tx_burst    = 0;
    logic        no_gaps     = 1'b0;
    logic        hold_req    = 1'b0;
    logic        hold_done;
    int          hold_left;
    int          rx_left;
    int unsigned rx_pick;
    cfg_t        cur_cfg;

    pwm_pulse_width_bit_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pwmd_frame_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (chk_fails),
        .frames_pending (chk_pending),
        .frames_checked (chk_frames)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // frame receiver: random ready runs, one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_left       <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD;
            hold_done     <= 1'b1;
        end
        else if (rx_left != 0)
            rx_left <= rx_left - 1;
        else
        begin
            rx_pick = $urandom_range(99, 0);
            if (rx_pick < 55)
            begin
                m_axis_tready <= 1'b1;
                rx_left       <= $urandom_range(5, 0);
            end
            else if (rx_pick < 70)
            begin
                m_axis_tready <= 1'b1;
                rx_left       <= $urandom_range(80, 20);
            end
            else if (rx_pick < 95)
            begin
                m_axis_tready <= 1'b0;
                rx_left       <= $urandom_range(2, 0);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                rx_left       <= $urandom_range(39, 9);
            end
        end
    end

    function automatic cfg_t make_cfg(input logic idle_high, input logic short_one,
                                      input logic [COUNT_W-1:0] min_w,
                                      input logic [COUNT_W-1:0] thr_w,
                                      input logic [COUNT_W-1:0] max_w,
                                      input logic [COUNT_W-1:0] gap_w,
                                      input logic [BITS_W-1:0] n_bits,
                                      input logic msb);
        cfg_t c;
        c.idle_is_high   = idle_high;
        c.one_is_short   = short_one;
        c.min_pulse      = min_w;
        c.threshold      = thr_w;
        c.max_pulse      = max_w;
        c.max_gap        = gap_w;
        c.bits_per_frame = n_bits;
        c.msb_first      = msb;
        return c;
    endfunction

    function automatic cfg_t rand_config();
        logic [COUNT_W-1:0] max_w;
        logic [COUNT_W-1:0] gap_w;
        logic [BITS_W-1:0]  n_bits;
        int unsigned        r;
        max_w = ($urandom_range(9, 0) == 0) ? '1 : COUNT_W'($urandom_range(10, 2));
        gap_w = ($urandom_range(9, 0) == 0) ? '1 : COUNT_W'($urandom_range(8, 0));
        r = $urandom_range(99, 0);
        if (r < 80)
            n_bits = BITS_W'($urandom_range(8, 1));
        else if (r < 90)
            n_bits = '0;
        else if (r < 95)
            n_bits = BITS_W'($urandom_range(20, 9));
        else
            n_bits = BITS_W'($urandom_range(127, 65));
        return make_cfg(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                        COUNT_W'($urandom_range(3, 0)), COUNT_W'($urandom_range(6, 1)),
                        max_w, gap_w, n_bits, 1'($urandom_range(1, 0)));
    endfunction

    // pulse width aimed at one of the bound classes of the current setting
    function automatic int unsigned pulse_len(input cfg_t c);
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 10)
        begin
            lo = 1;
            hi = (c.min_pulse > 1) ? c.min_pulse - 1 : 1;
        end
        else if (r < 50)
        begin
            lo = (c.min_pulse > 1) ? c.min_pulse : 1;
            hi = (c.threshold > 1) ? c.threshold - 1 : 1;
        end
        else if (r < 90)
        begin
            lo = (c.threshold > c.min_pulse) ? c.threshold : c.min_pulse;
            if (lo == 0)
                lo = 1;
            hi = c.max_pulse;
        end
        else
        begin
            lo = c.max_pulse + 1;
            hi = lo + 2;
        end
        if (lo > 24)
            lo = $urandom_range(24, 1);
        if (hi < lo)
            hi = lo;
        if (hi > lo + 4)
            hi = lo + 4;
        return $urandom_range(hi, lo);
    endfunction

    // idle run after a pulse, sometimes right at or past the gap limit
    function automatic int unsigned gap_len(input cfg_t c);
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60)
        begin
            lo = 1;
            hi = c.max_gap;
        end
        else if (r < 80)
        begin
            lo = (c.max_gap != 0) ? c.max_gap : 1;
            hi = lo;
        end
        else
        begin
            lo = c.max_gap + 1;
            hi = lo + 1;
        end
        if (lo > 30)
            lo = $urandom_range(4, 1);
        if (hi < lo)
            hi = lo;
        if (hi > lo + 3)
            hi = lo + 3;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        if (tx_burst != 0)
        begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 20)
        begin
            tx_burst = $urandom_range(80, 20);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic put_sample(input logic level);
        int unsigned g;
        g = sender_gap();
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-1){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic put_pulse(input int unsigned active_len, input int unsigned idle_len);
        repeat (active_len) put_sample(~cur_cfg.idle_is_high);
        repeat (idle_len) put_sample(cur_cfg.idle_is_high);
    endtask

    task automatic pause_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (chk_pending != 0);
    endtask

    task automatic drain();
        pause_for_results();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        drain();
        write_reg(REG_IDLE_IS_HIGH, CFG_W'(c.idle_is_high));
        write_reg(REG_ONE_IS_SHORT, CFG_W'(c.one_is_short));
        write_reg(REG_MIN_PULSE, c.min_pulse);
        write_reg(REG_THRESHOLD, c.threshold);
        write_reg(REG_MAX_PULSE, c.max_pulse);
        write_reg(REG_MAX_GAP, c.max_gap);
        write_reg(REG_BITS_FRAME, CFG_W'(c.bits_per_frame));
        write_reg(REG_MSB_FIRST, CFG_W'(c.msb_first));
        cfg_we  <= 1'b0;
        cur_cfg = c;
        n_configs++;
    endtask

    // mostly well-formed pulse trains, some random line noise
    task automatic run_phase(input int n_items, input bit quick);
        int first;
        int unsigned r;
        bit paused;
        first  = items_sent;
        paused = 1'b0;
        while (items_sent - first < n_items)
        begin
            if (!paused && items_sent - first >= n_items / 2)
            begin
                pause_for_results();
                paused = 1'b1;
            end
            r = $urandom_range(99, 0);
            if (quick)
                put_pulse($urandom_range(2, 1), $urandom_range(2, 1));
            else if (r < 88)
                put_pulse(pulse_len(cur_cfg), gap_len(cur_cfg));
            else
                repeat ($urandom_range(6, 1)) put_sample(1'($urandom_range(1, 0)));
        end
    endtask

    initial
    begin
        cur_cfg = make_cfg(1'b0, 1'b0, 2, 40, 100, 200, 24, 1'b1);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: busy line first, then a pulse below the minimum
        put_sample(1'b1);
        put_sample(1'b0);
        put_pulse(1, 1);

        // short and long symbols, full frame, too-long pulse, gap timeout
        load_config(make_cfg(1'b0, 1'b1, 2, 3, 5, 3, 3, 1'b1));
        put_pulse(2, 1);
        put_pulse(3, 1);
        put_pulse(2, 3);
        put_pulse(6, 1);
        put_pulse(2, 5);

        // 64-bit frames lsb first with pulse and gap limits at top values, then msb first
        // with an oversized length that the next setting cuts short
        load_config(make_cfg(1'b1, 1'b0, 0, 2, '1, '1, 64, 1'b0));
        run_phase(200, 1'b1);
        load_config(make_cfg(1'b0, 1'b1, 0, 2, '1, '1, 127, 1'b1));
        run_phase(70, 1'b1);
        // every pulse too short
        load_config(make_cfg(1'b1, 1'b1, '1, '1, '1, 0, 1, 1'b0));
        run_phase(20, 1'b0);
        // every pulse too long, zero length frame
        load_config(make_cfg(1'b0, 1'b0, 0, 1, 0, '1, 0, 1'b1));
        run_phase(20, 1'b0);

        // one frame per pulse while the receiver holds off
        load_config(make_cfg(1'b0, 1'b1, 0, 2, '1, 3, 1, 1'b1));
        hold_req <= 1'b1;
        no_gaps = 1'b1;
        repeat (30) put_pulse(1, 1);
        no_gaps = 1'b0;

        while (items_sent < 480)
        begin
            load_config(rand_config());
            run_phase($urandom_range(40, 20), 1'b0);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("sent %0d line samples under %0d register settings, %0d frames compared",
                 items_sent, n_configs, chk_frames);
        $display("covered both polarities and bit orders, 64-bit frames, bound errors, "
                 , "timeouts and a long output stall");
        if (chk_fails == 0 && chk_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
